/* hw/rtl/ttip_pkg.sv */
// Shared constants, types and codes for the text to integer parser.
`default_nettype none

package ttip_pkg;

  localparam int VALUE_BITS = 64;
  localparam int MAX_CHARS  = 255;
  localparam int CHAR_W     = $clog2(MAX_CHARS + 1);
  localparam int OUT_W      = 64;
  localparam int OFF_W      = 8;
  localparam int BASE_W     = 6;
  localparam int PROD_W     = VALUE_BITS + BASE_W;
  localparam int CFG_IDX_W  = 1;

  localparam int MAX_BASE = 36;
  localparam int HEX_BASE = 16;
  localparam int OCT_BASE = 8;
  localparam int DEC_BASE = 10;
  localparam int MIN_BASE = 2;

  localparam logic [BASE_W-1:0] DIGIT_NONE        = '1;
  localparam logic [BASE_W-1:0] NUMBER_BASE_RESET = BASE_W'(DEC_BASE);
  localparam logic              SIGNED_MODE_RESET = 1'b1;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_NUMBER_BASE = 1'b0,
    CFG_SIGNED_MODE = 1'b1
  } cfg_index_t;

  typedef enum logic [2:0] {
    PH_SPACE,
    PH_SIGNED,
    PH_ZERO,
    PH_XSEEN,
    PH_DIGITS,
    PH_DONE
  } phase_t;

  typedef struct packed {
    logic                 write;
    logic [CFG_IDX_W-1:0] index;
    logic [BASE_W-1:0]    data;
  } cfg_t;

  // One classified input byte.
  typedef struct packed {
    logic [BASE_W-1:0] digit;
    logic              space;
    logic              minus;
    logic              plus;
    logic              xchar;
    logic              last;
  } cmd_t;

  typedef struct packed {
    logic [OUT_W-1:0] value;
    logic [OFF_W-1:0] end_offset;
    logic             overflowed;
    logic             any_digits;
    logic             base_invalid;
  } result_t;

endpackage

`default_nettype wire

/* hw/rtl/ttip_front.sv */
// Front end: classifies incoming bytes and queues them for the parse engine.
`default_nettype none

module ttip_front (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          push,
  input  wire logic [7:0]    text_byte,
  input  wire logic          last_byte,
  output logic               full,
  input  wire logic          cmd_take,
  output ttip_pkg::cmd_t     cmd,
  output logic               cmd_avail
);
  import ttip_pkg::*;

  localparam int DEPTH = 4;
  localparam int AW    = $clog2(DEPTH);

  localparam logic [7:0] CH_ZERO    = 8'h30;
  localparam logic [7:0] CH_NINE    = 8'h39;
  localparam logic [7:0] CH_UP_A    = 8'h41;
  localparam logic [7:0] CH_UP_Z    = 8'h5a;
  localparam logic [7:0] CH_LO_A    = 8'h61;
  localparam logic [7:0] CH_LO_Z    = 8'h7a;
  localparam logic [7:0] CH_TAB     = 8'h09;
  localparam logic [7:0] CH_CR      = 8'h0d;
  localparam logic [7:0] CH_BLANK   = 8'h20;
  localparam logic [7:0] CH_MINUS   = 8'h2d;
  localparam logic [7:0] CH_PLUS    = 8'h2b;
  localparam logic [7:0] CH_UP_X    = 8'h58;
  localparam logic [7:0] CH_LO_X    = 8'h78;
  localparam logic [7:0] UP_BIAS    = CH_UP_A - 8'd10;
  localparam logic [7:0] LO_BIAS    = CH_LO_A - 8'd10;

  cmd_t          queue [DEPTH];
  logic [AW-1:0] wr_ptr;
  logic [AW-1:0] rd_ptr;
  logic [AW:0]   count;
  logic          wr_en;
  cmd_t          cmd_in;
  logic [7:0]    code;

  always_comb begin
    code = 8'hff;
    if (text_byte >= CH_ZERO && text_byte <= CH_NINE) begin
      code = text_byte - CH_ZERO;
    end else if (text_byte >= CH_UP_A && text_byte <= CH_UP_Z) begin
      code = text_byte - UP_BIAS;
    end else if (text_byte >= CH_LO_A && text_byte <= CH_LO_Z) begin
      code = text_byte - LO_BIAS;
    end
    cmd_in.digit = (code == 8'hff) ? DIGIT_NONE : code[BASE_W-1:0];
    cmd_in.space = (text_byte >= CH_TAB && text_byte <= CH_CR) || (text_byte == CH_BLANK);
    cmd_in.minus = (text_byte == CH_MINUS);
    cmd_in.plus  = (text_byte == CH_PLUS);
    cmd_in.xchar = (text_byte == CH_UP_X) || (text_byte == CH_LO_X);
    cmd_in.last  = last_byte;
  end

  assign full      = (count == (AW+1)'(DEPTH));
  assign wr_en     = push && !full;
  assign cmd_avail = (count != '0);
  assign cmd       = queue[rd_ptr];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      queue[wr_ptr] <= cmd_in;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (wr_en) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (cmd_take) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      count <= count + (AW+1)'(wr_en) - (AW+1)'(cmd_take);
    end
  end

endmodule

`default_nettype wire

/* hw/rtl/ttip_back.sv */
// Parse engine: steps the number grammar one classified byte per cycle unless stalled, and forms results.
`default_nettype none

module ttip_back (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire ttip_pkg::cfg_t cfg,
  input  wire ttip_pkg::cmd_t cmd,
  input  wire logic           cmd_avail,
  output logic                cmd_take,
  output logic                res_valid,
  output ttip_pkg::result_t   res,
  input  wire logic           res_full
);
  import ttip_pkg::*;

  localparam logic [VALUE_BITS-1:0] VALUE_TOP  = {1'b1, {(VALUE_BITS-1){1'b0}}};
  localparam logic [VALUE_BITS-1:0] VALUE_MASK = '1;

  // Configuration registers.
  logic [BASE_W-1:0] number_base;
  logic              signed_mode;

  // Parse state.
  phase_t                phase, phase_next;
  logic                  negative_sign, negative_sign_next;
  logic [BASE_W-1:0]     active_base, active_base_next;
  logic [VALUE_BITS-1:0] accumulator, accumulator_next;
  logic [CHAR_W-1:0]     char_index, char_index_next;
  logic [CHAR_W-1:0]     stop_index, stop_index_next;
  logic                  saturated_flag, saturated_flag_next;
  logic                  digit_seen, digit_seen_next;
  logic                  mode_latched, mode_latched_next;
  logic                  base_bad, base_bad_next;

  // Finish stage: final state of a string, waiting to become a result word.
  logic                  fin_valid;
  logic [VALUE_BITS-1:0] fin_acc;
  logic                  fin_sat;
  logic                  fin_neg;
  logic                  fin_mode;
  logic                  fin_bad;
  logic                  fin_seen;
  logic [CHAR_W-1:0]     fin_stop;

  logic                  first;
  phase_t                ph;
  logic                  do_first;
  logic                  do_digit;
  logic                  take;
  logic [BASE_W-1:0]     take_d;
  logic [BASE_W-1:0]     mul_base;
  logic [PROD_W-1:0]     product;
  logic [VALUE_BITS-1:0] limit;
  logic                  fin_room;
  logic                  fin_load;
  logic                  fin_drain;
  logic [VALUE_BITS-1:0] mag;
  logic [VALUE_BITS-1:0] signed_val;
  logic [VALUE_BITS-1:0] unsigned_val;

  always_ff @(posedge clk) begin
    if (rst) begin
      number_base <= NUMBER_BASE_RESET;
      signed_mode <= SIGNED_MODE_RESET;
    end else if (cfg.write) begin
      if (cfg.index == CFG_NUMBER_BASE) begin
        number_base <= cfg.data;
      end
      if (cfg.index == CFG_SIGNED_MODE) begin
        signed_mode <= cfg.data[0];
      end
    end
  end

  always_comb begin
    first = (phase == PH_SPACE) && (char_index == '0);

    phase_next          = phase;
    negative_sign_next  = negative_sign;
    active_base_next    = first ? number_base : active_base;
    mode_latched_next   = first ? signed_mode : mode_latched;
    base_bad_next       = first ? ((number_base == BASE_W'(1)) ||
                                   (number_base > BASE_W'(MAX_BASE)))
                                : base_bad;
    accumulator_next    = accumulator;
    stop_index_next     = stop_index;
    saturated_flag_next = saturated_flag;
    digit_seen_next     = digit_seen;
    char_index_next     = (char_index < CHAR_W'(MAX_CHARS)) ? char_index + 1'b1
                                                             : char_index;

    ph       = (first && base_bad_next) ? PH_DONE : phase;
    do_first = 1'b0;
    do_digit = 1'b0;
    take     = 1'b0;
    take_d   = '0;

    unique case (ph)
      PH_SPACE: begin
        if (cmd.space) begin
          phase_next = PH_SPACE;
        end else if (cmd.minus) begin
          negative_sign_next = 1'b1;
          phase_next         = PH_SIGNED;
        end else if (cmd.plus) begin
          phase_next = PH_SIGNED;
        end else begin
          do_first = 1'b1;
        end
      end
      PH_SIGNED: do_first = 1'b1;
      PH_ZERO: begin
        if (cmd.xchar) begin
          phase_next = PH_XSEEN;
        end else begin
          do_digit = 1'b1;
        end
      end
      PH_XSEEN: begin
        if (cmd.digit < BASE_W'(HEX_BASE)) begin
          active_base_next = BASE_W'(HEX_BASE);
          take             = 1'b1;
          take_d           = cmd.digit;
          phase_next       = PH_DIGITS;
        end else begin
          phase_next = PH_DONE;
        end
      end
      PH_DIGITS: do_digit = 1'b1;
      PH_DONE:   phase_next = PH_DONE;
      default:   phase_next = PH_DONE;
    endcase

    // A leading zero in automatic or hex base counts as a digit and may open a prefix.
    if (do_first) begin
      if (((active_base_next == '0) || (active_base_next == BASE_W'(HEX_BASE))) &&
          (cmd.digit == '0)) begin
        if (active_base_next == '0) begin
          active_base_next = BASE_W'(OCT_BASE);
        end
        take       = 1'b1;
        take_d     = '0;
        phase_next = PH_ZERO;
      end else begin
        if (active_base_next == '0) begin
          active_base_next = BASE_W'(DEC_BASE);
        end
        do_digit = 1'b1;
      end
    end

    if (do_digit) begin
      if (cmd.digit < active_base_next) begin
        take       = 1'b1;
        take_d     = cmd.digit;
        phase_next = PH_DIGITS;
      end else begin
        phase_next = PH_DONE;
      end
    end

    // Overflow test: acc * base + d > limit, done at full product width.
    mul_base = (active_base_next >= BASE_W'(MIN_BASE)) ? active_base_next
                                                       : BASE_W'(MIN_BASE);
    product  = PROD_W'(accumulator) * PROD_W'(mul_base) + PROD_W'(take_d);
    if (mode_latched_next) begin
      limit = negative_sign_next ? VALUE_TOP : VALUE_TOP - 1'b1;
    end else begin
      limit = VALUE_MASK;
    end

    if (take) begin
      digit_seen_next = 1'b1;
      stop_index_next = char_index_next;
      if (!saturated_flag) begin
        if (product > PROD_W'(limit)) begin
          saturated_flag_next = 1'b1;
        end else begin
          accumulator_next = product[VALUE_BITS-1:0];
        end
      end
    end
  end

  assign fin_drain = fin_valid && !res_full;
  assign fin_room  = !fin_valid || !res_full;
  assign cmd_take  = cmd_avail && (!cmd.last || fin_room);
  assign fin_load  = cmd_take && cmd.last;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase          <= PH_SPACE;
      negative_sign  <= 1'b0;
      active_base    <= '0;
      accumulator    <= '0;
      char_index     <= '0;
      stop_index     <= '0;
      saturated_flag <= 1'b0;
      digit_seen     <= 1'b0;
      mode_latched   <= 1'b0;
      base_bad       <= 1'b0;
      fin_valid      <= 1'b0;
    end else begin
      if (cmd_take) begin
        if (cmd.last) begin
          // The string ends here: re-arm for the next one.
          phase          <= PH_SPACE;
          negative_sign  <= 1'b0;
          active_base    <= '0;
          accumulator    <= '0;
          char_index     <= '0;
          stop_index     <= '0;
          saturated_flag <= 1'b0;
          digit_seen     <= 1'b0;
          mode_latched   <= 1'b0;
          base_bad       <= 1'b0;
        end else begin
          phase          <= phase_next;
          negative_sign  <= negative_sign_next;
          active_base    <= active_base_next;
          accumulator    <= accumulator_next;
          char_index     <= char_index_next;
          stop_index     <= stop_index_next;
          saturated_flag <= saturated_flag_next;
          digit_seen     <= digit_seen_next;
          mode_latched   <= mode_latched_next;
          base_bad       <= base_bad_next;
        end
      end
      if (fin_load) begin
        fin_valid <= 1'b1;
      end else if (fin_drain) begin
        fin_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fin_load) begin
      fin_acc  <= accumulator_next;
      fin_sat  <= saturated_flag_next;
      fin_neg  <= negative_sign_next;
      fin_mode <= mode_latched_next;
      fin_bad  <= base_bad_next;
      fin_seen <= digit_seen_next;
      fin_stop <= stop_index_next;
    end
  end

  always_comb begin
    if (fin_sat) begin
      mag = fin_neg ? VALUE_TOP : VALUE_TOP - 1'b1;
    end else begin
      mag = fin_acc;
    end
    signed_val   = fin_neg ? (~mag + 1'b1) : mag;
    unsigned_val = fin_sat ? VALUE_MASK : (fin_neg ? (~fin_acc + 1'b1) : fin_acc);

    res = '0;
    if (fin_bad) begin
      res.base_invalid = 1'b1;
    end else begin
      res.value      = fin_mode ? OUT_W'($signed(signed_val)) : OUT_W'(unsigned_val);
      res.end_offset = fin_seen ? OFF_W'(fin_stop) : '0;
      res.overflowed = fin_sat;
      res.any_digits = fin_seen;
    end
  end

  assign res_valid = fin_valid;

endmodule

`default_nettype wire

/* hw/rtl/ttip_out_queue.sv */
// Two-entry result queue in front of the pop side.
`default_nettype none

module ttip_out_queue (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              wr,
  input  wire ttip_pkg::result_t wdata,
  input  wire logic              rd,
  output ttip_pkg::result_t      rdata,
  output logic                   full,
  output logic                   empty
);
  import ttip_pkg::*;

  localparam int DEPTH = 2;
  localparam int AW    = $clog2(DEPTH);

  result_t       slots [DEPTH];
  logic [AW-1:0] wr_ptr;
  logic [AW-1:0] rd_ptr;
  logic [AW:0]   count;
  logic          wr_en;
  logic          rd_en;

  assign full  = (count == (AW+1)'(DEPTH));
  assign empty = (count == '0);
  assign wr_en = wr && !full;
  assign rd_en = rd && !empty;
  assign rdata = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      slots[wr_ptr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (wr_en) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (rd_en) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      count <= count + (AW+1)'(wr_en) - (AW+1)'(rd_en);
    end
  end

endmodule

`default_nettype wire

/* hw/rtl/text_to_integer_parser.sv */
// Top level of the streaming text to integer parser.
`default_nettype none

// Takes a string one byte a cycle through push/full, with last_byte on its final byte, and
// returns one result word per string through empty/pop. A byte queue of four words
// sits in front of a parse engine that handles one byte each cycle, though a string's
// last byte waits while results back up; the sustained rate is one byte per cycle while
// results are popped. The engine's single multiply-add by the base, with its overflow
// compare, sets that cycle. number_base and signed_mode take effect from the next string;
// write them only while no string is in flight.
module text_to_integer_parser (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           push,
  output logic                                full,
  input  wire logic [7:0]                     text_byte,
  input  wire logic                           last_byte,
  output logic                                empty,
  input  wire logic                           pop,
  output logic [ttip_pkg::OUT_W-1:0]          parsed_value,
  output logic [ttip_pkg::OFF_W-1:0]          end_offset,
  output logic                                overflowed,
  output logic                                any_digits,
  output logic                                base_invalid,
  input  wire logic                           cfg_write,
  input  wire logic [ttip_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [ttip_pkg::BASE_W-1:0]    cfg_data
);
  import ttip_pkg::*;

  cfg_t    cfg;
  cmd_t    cmd;
  logic    cmd_avail;
  logic    cmd_take;
  logic    res_valid;
  result_t res;
  result_t head;
  logic    res_full;

  assign cfg.write = cfg_write;
  assign cfg.index = cfg_index;
  assign cfg.data  = cfg_data;

  ttip_front u_front (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .text_byte (text_byte),
    .last_byte (last_byte),
    .full      (full),
    .cmd_take  (cmd_take),
    .cmd       (cmd),
    .cmd_avail (cmd_avail)
  );

  ttip_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .cmd       (cmd),
    .cmd_avail (cmd_avail),
    .cmd_take  (cmd_take),
    .res_valid (res_valid),
    .res       (res),
    .res_full  (res_full)
  );

  ttip_out_queue u_out_queue (
    .clk   (clk),
    .rst   (rst),
    .wr    (res_valid),
    .wdata (res),
    .rd    (pop),
    .rdata (head),
    .full  (res_full),
    .empty (empty)
  );

  assign parsed_value = head.value;
  assign end_offset   = head.end_offset;
  assign overflowed   = head.overflowed;
  assign any_digits   = head.any_digits;
  assign base_invalid = head.base_invalid;

endmodule

`default_nettype wire

/* hw/rtl/ttip_checker.sv */
// Port-level checks for the text to integer parser, bound to its top level.
`default_nettype none

module ttip_checker (
  input wire logic                           clk,
  input wire logic                           rst,
  input wire logic                           full,
  input wire logic                           empty,
  input wire logic                           pop,
  input wire logic [ttip_pkg::OUT_W-1:0]     parsed_value,
  input wire logic [ttip_pkg::OFF_W-1:0]     end_offset,
  input wire logic                           overflowed,
  input wire logic                           any_digits,
  input wire logic                           base_invalid
);

  // Both queues come out of reset empty.
  a_reset_empty: assert property (@(posedge clk) rst |=> empty && !full)
    else $error("queues not empty after reset");

  // A waiting result word holds until it is popped.
  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    (!empty && !pop) |=> (!empty && $stable(parsed_value) && $stable(end_offset)))
    else $error("result word changed while waiting");

  // An invalid base yields a result that is all zero apart from its base_invalid flag.
  a_bad_base_zero: assert property (@(posedge clk) disable iff (rst)
    (!empty && base_invalid) |->
      (parsed_value == '0 && end_offset == '0 && !overflowed && !any_digits))
    else $error("invalid base result not cleared");

  // Without digits there is neither an offset nor an overflow.
  a_no_digit_fields: assert property (@(posedge clk) disable iff (rst)
    (!empty && !any_digits) |-> (end_offset == '0 && !overflowed))
    else $error("offset or overflow without digits");

endmodule

bind text_to_integer_parser ttip_checker u_checker (.*);

`default_nettype wire

/* tb/tb_text_to_integer_parser.sv */
// Self-checking testbench for the streaming text to integer parser.
module tb_text_to_integer_parser;
  import ttip_pkg::*;

  localparam int DRAIN_CYCLES = 8;
  localparam int PHASE_BYTES = 75;
  localparam logic [63:0] VALUE_MASK = {64{1'b1}} >> (64 - VALUE_BITS);
  localparam logic [63:0] TOP_BIT = 64'd1 << (VALUE_BITS - 1);

  typedef struct {
    logic [7:0] code;
    logic       last;
  } text_item_t;

  logic                 clk;
  logic                 rst = 1'b1;
  logic                 push = 1'b0;
  logic                 full;
  logic [7:0]           text_byte = '0;
  logic                 last_byte = 1'b0;
  logic                 empty;
  logic                 pop = 1'b0;
  logic [OUT_W-1:0]     parsed_value;
  logic [OFF_W-1:0]     end_offset;
  logic                 overflowed;
  logic                 any_digits;
  logic                 base_invalid;
  logic                 cfg_write = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [BASE_W-1:0]    cfg_data = '0;

  text_item_t pending_bytes[$];
  result_t    expected_results[$];
  int         send_idle_pct = 35;
  int         recv_idle_pct = 51;
  int         fail_count = 0;
  int         bytes_queued = 0;

  // Configuration as last written, and the parse state of the current string.
  logic [BASE_W-1:0] cfg_radix = NUMBER_BASE_RESET;
  logic              cfg_signed = SIGNED_MODE_RESET;
  phase_t            scan_phase;
  logic              minus_seen;
  logic [BASE_W-1:0] radix;
  logic [63:0]       magnitude;
  int                byte_count;
  int                digits_end;
  logic              clipped;
  logic              got_digit;
  logic              signed_latched;
  logic              radix_bad;

  text_to_integer_parser dut (.*);

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  function automatic int digit_value(input logic [7:0] c);
    if (c >= "0" && c <= "9") return int'(c) - int'("0");
    if (c >= "A" && c <= "Z") return int'(c) - int'("A") + 10;
    if (c >= "a" && c <= "z") return int'(c) - int'("a") + 10;
    return 99;
  endfunction

  function automatic logic [7:0] digit_char(input int d);
    if (d < 10) return 8'(int'("0") + d);
    return 8'(($urandom_range(1) ? int'("a") : int'("A")) + d - 10);
  endfunction

  function void restart_scan();
    scan_phase = PH_SPACE;
    minus_seen = 1'b0;
    radix = '0;
    magnitude = '0;
    byte_count = 0;
    digits_end = 0;
    clipped = 1'b0;
    got_digit = 1'b0;
    signed_latched = 1'b0;
    radix_bad = 1'b0;
  endfunction

  // Once the magnitude has saturated, digits still move the end offset.
  function void accept_digit(input int d);
    logic [63:0] b;
    logic [63:0] lim;
    b = (radix >= MIN_BASE) ? 64'(radix) : 64'(MIN_BASE);
    got_digit = 1'b1;
    digits_end = byte_count;
    if (!clipped) begin
      if (signed_latched) lim = minus_seen ? TOP_BIT : TOP_BIT - 64'd1;
      else lim = VALUE_MASK;
      if (magnitude > (lim - 64'(d)) / b) clipped = 1'b1;
      else magnitude = magnitude * b + 64'(d);
    end
  endfunction

  function void in_digit_position(input logic [7:0] c);
    int d;
    d = digit_value(c);
    if (d < int'(radix)) begin
      accept_digit(d);
      scan_phase = PH_DIGITS;
    end else begin
      scan_phase = PH_DONE;
    end
  endfunction

  function void first_char(input logic [7:0] c);
    if ((radix == 0 || radix == HEX_BASE) && c == "0") begin
      if (radix == 0) radix = BASE_W'(OCT_BASE);
      accept_digit(0);
      scan_phase = PH_ZERO;
    end else begin
      if (radix == 0) radix = BASE_W'(DEC_BASE);
      in_digit_position(c);
    end
  endfunction

  function void parse_byte(input logic [7:0] c, input logic last);
    result_t     want;
    logic [63:0] mag;
    logic [63:0] v;
    // Base and mode are taken on the first byte of each string.
    if (scan_phase == PH_SPACE && byte_count == 0) begin
      radix = cfg_radix;
      signed_latched = cfg_signed;
      radix_bad = (radix == 1 || radix > MAX_BASE);
      if (radix_bad) scan_phase = PH_DONE;
    end
    if (byte_count < MAX_CHARS) byte_count++;
    case (scan_phase)
      PH_SPACE: begin
        if (!((c >= 9 && c <= 13) || c == 32)) begin
          if (c == "-") begin
            minus_seen = 1'b1;
            scan_phase = PH_SIGNED;
          end else if (c == "+") begin
            scan_phase = PH_SIGNED;
          end else begin
            first_char(c);
          end
        end
      end
      PH_SIGNED: first_char(c);
      PH_ZERO: begin
        if (c == "x" || c == "X") scan_phase = PH_XSEEN;
        else in_digit_position(c);
      end
      PH_XSEEN: begin
        if (digit_value(c) < HEX_BASE) begin
          radix = BASE_W'(HEX_BASE);
          accept_digit(digit_value(c));
          scan_phase = PH_DIGITS;
        end else begin
          scan_phase = PH_DONE;
        end
      end
      PH_DIGITS: in_digit_position(c);
      default: ;
    endcase
    if (last) begin
      if (radix_bad) begin
        v = '0;
      end else if (signed_latched) begin
        if (clipped) mag = minus_seen ? TOP_BIT : TOP_BIT - 64'd1;
        else mag = magnitude;
        v = (minus_seen ? 64'd0 - mag : mag) & VALUE_MASK;
        if (v[VALUE_BITS-1]) v = v | ~VALUE_MASK;
      end else if (clipped) begin
        v = VALUE_MASK;
      end else begin
        v = (minus_seen ? 64'd0 - magnitude : magnitude) & VALUE_MASK;
      end
      want.value = v;
      want.end_offset = (!radix_bad && got_digit) ? OFF_W'(digits_end) : '0;
      want.overflowed = !radix_bad && clipped;
      want.any_digits = !radix_bad && got_digit;
      want.base_invalid = radix_bad;
      expected_results.push_back(want);
      restart_scan();
    end
  endfunction

  function void send_string(input logic [7:0] text[$]);
    foreach (text[i]) pending_bytes.push_back(text_item_t'{text[i], i == text.size() - 1});
    bytes_queued += text.size();
  endfunction

  function void send_text(input string s);
    logic [7:0] text[$];
    for (int i = 0; i < s.len(); i++) text.push_back(s[i]);
    send_string(text);
  endfunction

  // Mostly well-formed numbers in the configured base, with some noise strings.
  function void send_random_string();
    logic [7:0]  text[$];
    logic [7:0]  digits[$];
    logic [63:0] v;
    int          kind;
    int          r;
    int          gb;
    kind = $urandom_range(99);
    if (kind < 8) begin
      repeat ($urandom_range(12, 1)) text.push_back(8'($urandom_range(255)));
    end else begin
      // Long padding pushes the digits past the point where the counter saturates.
      if (kind < 11) repeat ($urandom_range(270, 250)) text.push_back(" ");
      repeat ($urandom_range(2)) begin
        r = $urandom_range(5);
        text.push_back(r == 5 ? 8'd32 : 8'(9 + r));
      end
      r = $urandom_range(3);
      if (r == 0) text.push_back("-");
      else if (r == 1) text.push_back("+");
      gb = (cfg_radix >= MIN_BASE && cfg_radix <= MAX_BASE) ? int'(cfg_radix) : DEC_BASE;
      r = $urandom_range(7);
      if (r < 2) begin
        text.push_back("0");
        text.push_back($urandom_range(1) ? "x" : "X");
        if (cfg_radix == 0 || cfg_radix == HEX_BASE) gb = HEX_BASE;
      end else if (r == 2) begin
        text.push_back("0");
        if (cfg_radix == 0) gb = OCT_BASE;
      end
      r = $urandom_range(9);
      if (r < 2) begin
        // Values right at the saturation limits.
        case ($urandom_range(3))
          0: v = TOP_BIT - 64'd1;
          1: v = TOP_BIT;
          2: v = VALUE_MASK;
          default: v = VALUE_MASK / 64'(gb);
        endcase
        v = v + 64'($urandom_range(2)) - 64'd1;
        do begin
          digits.push_front(digit_char(int'(v % 64'(gb))));
          v = v / 64'(gb);
        end while (v != 0);
        text = {text, digits};
      end else begin
        repeat ((r == 9) ? $urandom_range(70, 15) : $urandom_range(8))
          text.push_back(digit_char($urandom_range(gb - 1)));
      end
      if ($urandom_range(1)) begin
        repeat ($urandom_range(4, 1))
          text.push_back($urandom_range(3) == 0 ? 8'($urandom_range(255))
                                                : digit_char($urandom_range(35)));
      end
    end
    if (text.size() == 0) text.push_back(digit_char($urandom_range(35)));
    send_string(text);
  endfunction

  function void note_failure(input string msg);
    fail_count++;
    if (fail_count <= 10) $display("%s", msg);
  endfunction

  task automatic wait_idle();
    while (pending_bytes.size() != 0 || push || expected_results.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic write_config(input logic [BASE_W-1:0] base_val, input logic mode_val);
    @(posedge clk);
    cfg_write <= 1'b1;
    cfg_index <= CFG_NUMBER_BASE;
    cfg_data <= base_val;
    @(posedge clk);
    cfg_index <= CFG_SIGNED_MODE;
    cfg_data <= BASE_W'(mode_val);
    @(posedge clk);
    cfg_write <= 1'b0;
    cfg_radix = base_val;
    cfg_signed = mode_val;
    @(negedge clk);
  endtask

  // A word is held until accepted; a new one is loaded only after acceptance.
  always @(posedge clk) begin : drive_bytes
    text_item_t nxt;
    if (rst) begin
      push <= 1'b0;
    end else begin
      if (push && !full) parse_byte(text_byte, last_byte);
      if (!push || !full) begin
        if (pending_bytes.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          nxt = pending_bytes.pop_front();
          push <= 1'b1;
          text_byte <= nxt.code;
          last_byte <= nxt.last;
        end else begin
          push <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin : check_results
    result_t want;
    if (rst) begin
      pop <= 1'b0;
    end else begin
      if (pop && !empty) begin
        if (expected_results.size() == 0) begin
          note_failure($sformatf("unexpected result word: value %h offset %0d",
                                 parsed_value, end_offset));
        end else begin
          want = expected_results.pop_front();
          if (parsed_value !== want.value || end_offset !== want.end_offset ||
              overflowed !== want.overflowed || any_digits !== want.any_digits ||
              base_invalid !== want.base_invalid)
            note_failure($sformatf({"result mismatch: expected %h/%0d/%b/%b/%b, ",
                                    "got %h/%0d/%b/%b/%b (value/offset/ovf/digits/badbase)"},
                                   want.value, want.end_offset, want.overflowed,
                                   want.any_digits, want.base_invalid, parsed_value,
                                   end_offset, overflowed, any_digits, base_invalid));
        end
      end
      pop <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  initial begin : run_stimulus
    logic [7:0] nul_text[$];
    int         base_plan[12];
    int         mode_plan[12];
    base_plan = '{0, 16, 2, 36, 8, 1, 10, 37, 63, 0, 16, 0};
    mode_plan = '{1, 0, 1, 0, 0, 1, 1, 0, 1, 0, 0, 1};
    restart_scan();
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Reset configuration: whitespace and sign, sign alone, a zero byte, early stop.
    send_text(" \t-12");
    send_text("+");
    nul_text.push_back(8'h00);
    send_string(nul_text);
    send_text("7a");
    wait_idle();

    // Automatic base, unsigned: hex prefix, prefix with no hex digit, octal, minus.
    write_config('0, 1'b0);
    send_text("0x1F");
    send_text("0x");
    send_text("0Xg");
    send_text("017");
    send_text("-9");
    wait_idle();

    for (int p = 0; p < 12; p++) begin
      if (p == 4) begin
        send_idle_pct = 51;
        recv_idle_pct = 35;
      end else if (p == 8) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      if (p == 11) write_config(BASE_W'($urandom_range(63)), 1'($urandom_range(1)));
      else write_config(BASE_W'(base_plan[p]), 1'(mode_plan[p]));
      bytes_queued = 0;
      while (bytes_queued < PHASE_BYTES) send_random_string();
      wait_idle();
    end

    if (fail_count == 0) $display("ALL CHECKS PASSED");
    else $display("CHECKS FAILED");
    $finish;
  end

  initial begin
    #4000000;
    $display("CHECKS FAILED");
    $finish;
  end

endmodule

/* text_to_integer_parser.f */
hw/rtl/ttip_pkg.sv
hw/rtl/ttip_front.sv
hw/rtl/ttip_back.sv
hw/rtl/ttip_out_queue.sv
hw/rtl/text_to_integer_parser.sv
hw/rtl/ttip_checker.sv
tb/tb_text_to_integer_parser.sv
